// ----- sv/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer to decimal text package
// Character codes and the command and status structs that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [6:0] CHAR_NINE  = 7'd57;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
    logic emit_sign;
  } itoa_cmd_t;

  typedef struct packed {
    logic bit_last;
    logic top_zero;
    logic one_left;
    logic negative;
  } itoa_sts_t;

endpackage

// ----- sv/itoa_dpath.sv -----
// ----------------------------------------------------------------------------
// Integer to decimal text datapath
// Holds the magnitude, converts it to packed decimal one bit per cycle
// with the shift-and-add-three method, and shifts out digits from the top.
// ----------------------------------------------------------------------------
module itoa_dpath import itoa_pkg::*; #(
  parameter int INPUT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic signed [INPUT_WIDTH-1:0] value,
  input  itoa_cmd_t                     cmd,
  output itoa_sts_t                     sts,
  output logic [6:0]                    character
);

  localparam int NUM_DIGITS = ((INPUT_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BCNT_W     = $clog2(INPUT_WIDTH + 1);
  localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

  logic [INPUT_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BCNT_W-1:0]      bit_cnt;
  logic [DCNT_W-1:0]      digit_cnt;
  logic                   neg;
  logic [3:0]             top_digit;

  always_comb begin
    logic [3:0] dig;
    dig = 4'd0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      dig = bcd[4*d +: 4];
      bcd_adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg       <= value[INPUT_WIDTH-1];
      mag       <= value[INPUT_WIDTH-1] ? INPUT_WIDTH'(-value) : INPUT_WIDTH'(value);
      bcd       <= '0;
      bit_cnt   <= BCNT_W'(INPUT_WIDTH);
      digit_cnt <= DCNT_W'(NUM_DIGITS);
    end else if (cmd.step) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[INPUT_WIDTH-1]};
      mag     <= {mag[INPUT_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt - BCNT_W'(1);
    end else if (cmd.shift) begin
      bcd       <= {bcd[BCD_W-5:0], 4'd0};
      digit_cnt <= digit_cnt - DCNT_W'(1);
    end
  end

  assign top_digit    = bcd[BCD_W-1 -: 4];
  assign sts.bit_last = (bit_cnt == BCNT_W'(1));
  assign sts.top_zero = (top_digit == 4'd0);
  assign sts.one_left = (digit_cnt == DCNT_W'(1));
  assign sts.negative = neg;
  assign character    = cmd.emit_sign ? CHAR_MINUS : CHAR_ZERO + {3'd0, top_digit};

endmodule

// ----- sv/itoa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Integer to decimal text controller
// Sequences load, conversion, leading zero removal, sign and digit output.
// ----------------------------------------------------------------------------
module itoa_ctrl import itoa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      last,
  input  itoa_sts_t sts,
  output itoa_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SKIP  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    out_valid  = 1'b0;
    last       = 1'b0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (sts.bit_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.top_zero && !sts.one_left) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = sts.negative ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        out_valid     = 1'b1;
        cmd.emit_sign = 1'b1;
        if (!out_stall) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_valid = 1'b1;
        last      = sts.one_left;
        if (!out_stall) begin
          cmd.shift = 1'b1;
          if (sts.one_left) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII text
// After an item is accepted, the magnitude is converted bit-serially to packed decimal,
// leading zero digits are shifted out, then an optional sign and the digits are shown;
// characters leave one per cycle while out_stall is low. A new item is taken only
// after the last character of the previous one has left.
// Reset is synchronous and returns the controller to idle; data is not cleared.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii import itoa_pkg::*; #(
  parameter int INPUT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [INPUT_WIDTH-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [6:0]                    character,
  output logic                          last
);

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last      (last),
    .sts       (sts),
    .cmd       (cmd)
  );

  itoa_dpath #(
    .INPUT_WIDTH (INPUT_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .character (character)
  );

endmodule

// ----- sv/itoa_checker.sv -----
// ----------------------------------------------------------------------------
// Integer to decimal text checker
// Port-level checks on the character stream, bound to the top level.
// ----------------------------------------------------------------------------
module itoa_checker import itoa_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] character,
  input logic       last
);

  // A stalled item holds its character and flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
    else $error("stalled output item changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CHAR_MINUS) ||
                  (character >= CHAR_ZERO && character <= CHAR_NINE))
    else $error("character is neither a sign nor a digit");

  // A sign is always followed by at least one digit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (character == CHAR_MINUS) |-> !last)
    else $error("sign marked as final character");

  // No new item is taken while a number is still being sent.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input accepted in the middle of a number");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("block not busy after accepting an item");

endmodule

bind signed_int_to_decimal_ascii itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .character (character),
  .last      (last)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for signed integer to decimal ASCII text
// Sends signed 32-bit integers and checks every character and last flag
// that comes back. A short table covers zero, single digits, powers of ten
// and both ends of the range. Random integers of every digit length then
// run under three stall patterns, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import itoa_pkg::*;

  localparam int WIDTH        = 32;
  localparam int NUM_PER_PASS = 85;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int STUCK_LIMIT  = 2000;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } text_char_t;

  typedef struct {
    logic signed [WIDTH-1:0] value;
    string                   text;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [WIDTH-1:0] value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [6:0]              character;
  logic                    last;

  text_char_t text_q[$];
  int         errors = 0;
  int         items_sent = 0;
  int         negatives_sent = 0;
  int         chars_seen = 0;
  int         send_idle_pct = 30;
  int         recv_stall_pct = 51;
  int         stall_pass = 0;
  int         stuck_cycles = 0;

  directed_row_t directed_rows[] = '{
    '{32'sd0,           "0"},
    '{32'sd1,           "1"},
    '{-32'sd1,          "-1"},
    '{32'sd9,           "9"},
    '{-32'sd9,          "-9"},
    '{32'sd10,          "10"},
    '{-32'sd10,         "-10"},
    '{32'sd99,          "99"},
    '{32'sd100,         "100"},
    '{-32'sd100,        "-100"},
    '{32'sd999999999,   "999999999"},
    '{32'sd1000000000,  "1000000000"},
    '{-32'sd1000000000, "-1000000000"},
    '{32'sd2147483647,  "2147483647"},
    '{-32'sd2147483647, "-2147483647"},
    '{32'h80000000,     "-2147483648"},
    '{32'sd12345,       ""},
    '{-32'sd67890,      ""},
    '{32'h55555555,     ""},
    '{32'hAAAAAAAA,     ""},
    '{32'sd1999999999,  ""},
    '{32'h12345678,     ""},
    '{-32'sd987654321,  ""}
  };

  signed_int_to_decimal_ascii #(.INPUT_WIDTH(WIDTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void push_decimal_text(logic signed [WIDTH-1:0] v);
    longint          wide;
    longint unsigned mag;
    logic [6:0]      digit_chars[$];
    bit              neg;
    neg  = v[WIDTH-1];
    wide = v;
    mag  = neg ? -wide : wide;
    do begin
      digit_chars.push_front(CHAR_ZERO + 7'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) text_q.push_back('{character: CHAR_MINUS, last: 1'b0});
    foreach (digit_chars[i])
      text_q.push_back('{character: digit_chars[i], last: i == digit_chars.size() - 1});
  endfunction

  function automatic void push_typed_text(string text);
    for (int i = 0; i < text.len(); i++)
      text_q.push_back('{character: 7'(text[i]), last: i == text.len() - 1});
  endfunction

  function automatic logic signed [WIDTH-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int              digits;
    bit              neg;
    if ($urandom_range(3) == 0) return $urandom;
    digits = $urandom_range(10, 1);
    lo = 1;
    repeat (digits - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (digits == 1) lo = 0;
    if (hi > 64'd2147483648) hi = 64'd2147483648;
    mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
    neg = 1'($urandom_range(1));
    if (!neg && mag == 64'd2147483648) mag = 64'd2147483647;
    return neg ? WIDTH'(-mag) : WIDTH'(mag);
  endfunction

  task automatic offer(input logic signed [WIDTH-1:0] v, input string text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    if (text.len() == 0) push_decimal_text(v);
    else push_typed_text(text);
    items_sent++;
    if (v[WIDTH-1]) negatives_sent++;
  endtask

  task automatic wait_for_text_drain();
    in_valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_pass == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(99) < recv_stall_pct;
      end
    end
  end

  always @(posedge clk) begin : text_check
    text_char_t want;
    if (!rst && out_valid && !out_stall) begin
      chars_seen++;
      if (text_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, got char %0d last %0b",
                 $time, character, last);
        errors++;
      end else begin
        want = text_q.pop_front();
        if (character !== want.character) begin
          $display("%0t: character mismatch: expected %0d, got %0d",
                   $time, want.character, character);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last flag mismatch: expected %0b, got %0b",
                   $time, want.last, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d characters outstanding",
               $time, STUCK_LIMIT, text_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) offer(directed_rows[i].value, directed_rows[i].text);
    for (int n = 0; n < NUM_PER_PASS; n++) offer(random_value(), "");
    wait_for_text_drain();

    stall_pass     = 1;
    send_idle_pct  = 51;
    recv_stall_pct = 30;
    for (int n = 0; n < NUM_PER_PASS; n++) offer(random_value(), "");

    stall_pass     = 2;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < NUM_PER_PASS; n++) offer(random_value(), "");
    in_valid <= 1'b0;

    while (text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d integers (%0d negative) into %0d characters,", items_sent,
             negatives_sent, chars_seen);
    $display("with input gaps, output stalls, a long output hold-off and a drain pause.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
